FILE: hw/rtl/hmmsr_pkg.sv
package hmmsr_pkg;

  localparam int DEF_SERIES       = 4;
  localparam int DEF_WINDOW_HOURS = 24;

  // Number of key registers that exist in the register map.
  localparam int KEY_REGS   = 4;
  localparam int CFG_IDX_W  = 3;

  localparam int TS_W    = 32;
  localparam int HOUR_W  = 21;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 16;
  localparam int DIV_W   = 12;
  localparam int MAG_W   = 32;
  localparam int SHIFT_W = 6;
  localparam int WORD_W  = 2 * VAL_W + SUM_W + CNT_W;

  localparam logic [TS_W-1:0]  CLOCK_FLOOR   = 32'd1000000000;
  localparam logic [DIV_W-1:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [CNT_W-1:0] CNT_MAX       = 16'hFFFF;
  localparam logic signed [SUM_W:0] SUM_HI   = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W:0] SUM_LO   = -49'sh0_8000_0000_0000;

  // Seconds to hours: the quotient is (ts * ceil(2^43 / 3600)) >> 43, exact for
  // every 32-bit timestamp.
  localparam logic [MAG_W-1:0] HOUR_MAGIC = 32'd2443359173;
  localparam int               HOUR_SHIFT = 43;
  // Hours to ring slots: ceil(2^27 / WINDOW_HOURS) is exact for 21-bit hours
  // and any window of up to 64 hours.
  localparam int               SLOT_SHIFT = 27;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_OUTSIDE = 3'd3;
  localparam logic [2:0] ST_RECORD  = 3'd4;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_DIVH,
    S_DIVM,
    S_CLR,
    S_CHK,
    S_FOLD,
    S_QRD,
    S_QDAT
  } state_e;

  typedef struct packed {
    logic               start;
    logic [TS_W-1:0]    dividend;
    logic [MAG_W-1:0]   magic;
    logic [SHIFT_W-1:0] shift;
    logic [DIV_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TS_W-1:0]  quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: hw/rtl/hmmsr_ram.sv
module hmmsr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/hmmsr_div.sv
module hmmsr_div import hmmsr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                  quot_step_q;
  logic                  rem_step_q;
  logic                  done_q;
  logic [TS_W-1:0]       dvd_q;
  logic [MAG_W-1:0]      mag_q;
  logic [SHIFT_W-1:0]    shift_q;
  logic [DIV_W-1:0]      dvs_q;
  logic [TS_W-1:0]       quot_q;
  logic [DIV_W-1:0]      rem_q;
  logic [TS_W-1:0]       mul_a;
  logic [MAG_W-1:0]      mul_b;
  logic [TS_W+MAG_W-1:0] prod;

  // One multiplier serves both steps: first the dividend times the scaled
  // reciprocal, then the quotient times the divisor to recover the remainder.
  assign mul_a = rem_step_q ? quot_q : dvd_q;
  assign mul_b = rem_step_q ? MAG_W'(dvs_q) : mag_q;
  assign prod  = {{MAG_W{1'b0}}, mul_a} * {{TS_W{1'b0}}, mul_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_step_q <= 1'b0;
      rem_step_q  <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      quot_step_q <= req_i.start;
      rem_step_q  <= quot_step_q;
      done_q      <= rem_step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q   <= req_i.dividend;
      mag_q   <= req_i.magic;
      shift_q <= req_i.shift;
      dvs_q   <= req_i.divisor;
    end
    if (quot_step_q) begin
      quot_q <= TS_W'(prod >> shift_q);
    end
    if (rem_step_q) begin
      rem_q <= DIV_W'(dvd_q - prod[TS_W-1:0]);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: hw/rtl/hourly_min_max_sum_ring.sv
// Hourly min/max/sum/count ring for up to SERIES keyed series.
// Input channel (in_valid_i/in_ready_o): one item per transfer, either an
// add of one Q16.16 reading or a read of the window of one series. An add
// gives one result; a read gives WINDOW_HOURS results, oldest hour first,
// or a single unknown-series result. last_o marks the final result.
// Output channel (out_valid_o/out_ready_i): one result per transfer.
// Configuration channel (cfg_valid_i/cfg_ready_o): writes a series key;
// always ready, and a changed key clears that series.
// Timing: the hour and the ring slot come from one shared multiply-by-
// reciprocal divider, two divisions per item of a known series. A stored
// add then clears each skipped hour in turn (at most WINDOW_HOURS-1), reads
// its bucket and folds it; an add outside the window answers after the two
// divisions, a dropped reading or unknown key straight after the lookup.
// A read then gives its buckets one after another (one RAM read each).
// The sequencer is back in idle, ready for the next item, once the last
// result is loaded, while that result may still wait in the output
// register; a stalled receiver holds the sequencer at its next result.
// Reset clears all keys, newest hours and bucket valid bits at once, so
// the block is ready as soon as reset is released.
module hourly_min_max_sum_ring import hmmsr_pkg::*; #(
  parameter int SERIES       = DEF_SERIES,
  parameter int WINDOW_HOURS = DEF_WINDOW_HOURS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    opcode_i,
  input  logic [31:0]             series_key_i,
  input  logic [TS_W-1:0]         timestamp_i,
  input  logic signed [VAL_W-1:0] sample_value_i,
  input  logic                    sample_valid_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              status_o,
  output logic                    hour_closed_o,
  output logic signed [VAL_W-1:0] bucket_min_o,
  output logic signed [VAL_W-1:0] bucket_max_o,
  output logic signed [SUM_W-1:0] bucket_sum_o,
  output logic [CNT_W-1:0]        bucket_count_o,
  output logic                    last_o
);

  localparam int SER_W  = (SERIES > 1) ? $clog2(SERIES) : 1;
  localparam int SLOT_W = $clog2(WINDOW_HOURS);
  localparam int DEPTH  = SERIES * WINDOW_HOURS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int K_W    = $clog2(WINDOW_HOURS + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_HOURS - 1);
  localparam logic [HOUR_W-1:0] WIN_H     = HOUR_W'(WINDOW_HOURS);
  localparam logic [MAG_W-1:0]  SLOT_MAGIC =
    MAG_W'(((longint'(1) << SLOT_SHIFT) + WINDOW_HOURS - 1) / WINDOW_HOURS);

  state_e state_q, state_d;

  logic [31:0]       keys_q [SERIES];
  logic [HOUR_W-1:0] lat_q  [SERIES];
  logic [DEPTH-1:0]  vld_q;

  logic                    op_q;
  logic [31:0]             key_q;
  logic [TS_W-1:0]         ts_q;
  logic signed [VAL_W-1:0] val_q;
  logic                    sval_q;
  logic [SER_W-1:0]        ser_q;
  logic [HOUR_W-1:0]       hour_q;
  logic [SLOT_W-1:0]       rslot_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [K_W-1:0]          cnt_q;
  logic                    closed_q;
  logic                    rd_vld_q;

  logic                    out_valid_q;
  logic [2:0]              out_status_q;
  logic                    out_closed_q;
  logic signed [VAL_W-1:0] out_min_q;
  logic signed [VAL_W-1:0] out_max_q;
  logic signed [SUM_W-1:0] out_sum_q;
  logic [CNT_W-1:0]        out_cnt_q;
  logic                    out_last_q;

  logic                    em_load;
  logic [2:0]              em_status;
  logic                    em_closed;
  logic signed [VAL_W-1:0] em_min;
  logic signed [VAL_W-1:0] em_max;
  logic signed [SUM_W-1:0] em_sum;
  logic [CNT_W-1:0]        em_cnt;
  logic                    em_last;

  logic                    match;
  logic [SER_W-1:0]        match_ser;
  logic                    out_free;
  logic                    cfg_we;
  logic [HOUR_W-1:0]       lasth;
  logic [HOUR_W-1:0]       skipped;
  logic [ADDR_W-1:0]       base;
  logic                    ram_we;
  logic                    ram_re;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [ADDR_W-1:0]       fold_addr;
  logic [WORD_W-1:0]       ram_wdata;
  logic [WORD_W-1:0]       ram_rdata;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic signed [VAL_W-1:0] old_min, old_max, new_min, new_max;
  logic signed [SUM_W-1:0] old_sum, new_sum;
  logic signed [SUM_W:0]   wide_sum;
  logic [CNT_W-1:0]        old_cnt, new_cnt;

  logic [HOUR_W-1:0]       back;
  logic [HOUR_W-1:0]       q_hour;
  logic                    live;

  hmmsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  hmmsr_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fold_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;

  // The lowest slot with an equal, nonzero key wins.
  always_comb begin
    match     = 1'b0;
    match_ser = '0;
    for (int s = SERIES - 1; s >= 0; s--) begin
      if (keys_q[s] != '0 && keys_q[s] == key_q) begin
        match     = 1'b1;
        match_ser = SER_W'(s);
      end
    end
  end

  assign lasth     = lat_q[ser_q];
  assign skipped   = hour_q - lasth;
  assign base      = ADDR_W'(ser_q) * ADDR_W'(WINDOW_HOURS);
  assign fold_addr = base + ADDR_W'(rslot_q);

  // Bucket fold. A bucket whose valid bit is clear reads as empty.
  assign {old_min, old_max, old_sum, old_cnt} = ram_rdata;
  assign wide_sum = {old_sum[SUM_W-1], old_sum} + (SUM_W + 1)'(val_q);

  always_comb begin
    if (!rd_vld_q) begin
      new_min = val_q;
      new_max = val_q;
      new_sum = SUM_W'(val_q);
      new_cnt = CNT_W'(1);
    end else begin
      new_min = (val_q < old_min) ? val_q : old_min;
      new_max = (val_q > old_max) ? val_q : old_max;
      if (wide_sum > SUM_HI) begin
        new_sum = SUM_W'(SUM_HI);
      end else if (wide_sum < SUM_LO) begin
        new_sum = SUM_W'(SUM_LO);
      end else begin
        new_sum = SUM_W'(wide_sum);
      end
      new_cnt = (old_cnt == CNT_MAX) ? CNT_MAX : old_cnt + 1'b1;
    end
  end

  assign ram_wdata = {new_min, new_max, new_sum, new_cnt};

  // Liveness of the hour that a read walks past.
  assign back   = HOUR_W'(WINDOW_HOURS - 1) - HOUR_W'(cnt_q);
  assign q_hour = hour_q - back;
  assign live   = (back <= hour_q) && (q_hour <= lasth) && ((lasth - q_hour) < WIN_H)
                  && rd_vld_q;

  always_comb begin
    state_d          = state_q;
    em_load          = 1'b0;
    em_status        = ST_STORED;
    em_closed        = 1'b0;
    em_min           = '0;
    em_max           = '0;
    em_sum           = '0;
    em_cnt           = '0;
    em_last          = 1'b1;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.magic    = HOUR_MAGIC;
    div_req.shift    = SHIFT_W'(HOUR_SHIFT);
    div_req.divisor  = SECS_PER_HOUR;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_raddr        = fold_addr;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (op_q == OP_ADD && (!sval_q || ts_q < CLOCK_FLOOR)) begin
          if (out_free) begin
            em_load   = 1'b1;
            em_status = ST_INVALID;
            state_d   = S_IDLE;
          end
        end else if (!match) begin
          if (out_free) begin
            em_load   = 1'b1;
            em_status = ST_UNKNOWN;
            state_d   = S_IDLE;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = (ts_q < CLOCK_FLOOR) ? '0 : ts_q;
          state_d          = S_DIVH;
        end
      end
      S_DIVH: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = TS_W'(div_rsp.quot[HOUR_W-1:0]);
          div_req.magic    = SLOT_MAGIC;
          div_req.shift    = SHIFT_W'(SLOT_SHIFT);
          div_req.divisor  = DIV_W'(WINDOW_HOURS);
          state_d          = S_DIVM;
        end
      end
      S_DIVM: begin
        if (div_rsp.done) begin
          if (op_q == OP_READ) begin
            state_d = S_QRD;
          end else if (hour_q > lasth && skipped < WIN_H) begin
            state_d = S_CLR;
          end else begin
            state_d = S_CHK;
          end
        end
      end
      S_CLR: begin
        if (cnt_q == K_W'(1)) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if ((lasth - hour_q) >= WIN_H) begin
          if (out_free) begin
            em_load   = 1'b1;
            em_status = ST_OUTSIDE;
            em_closed = closed_q;
            state_d   = S_IDLE;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        // The write waits for the output register so that it happens once.
        if (out_free) begin
          ram_we    = 1'b1;
          em_load   = 1'b1;
          em_status = ST_STORED;
          em_closed = closed_q;
          em_min    = new_min;
          em_max    = new_max;
          em_sum    = new_sum;
          em_cnt    = new_cnt;
          state_d   = S_IDLE;
        end
      end
      S_QRD: begin
        ram_re    = 1'b1;
        ram_raddr = base + ADDR_W'(slot_q);
        state_d   = S_QDAT;
      end
      S_QDAT: begin
        if (out_free) begin
          em_load   = 1'b1;
          em_status = ST_RECORD;
          em_last   = (cnt_q == K_W'(WINDOW_HOURS - 1));
          if (live) begin
            {em_min, em_max, em_sum, em_cnt} = ram_rdata;
          end
          state_d = em_last ? S_IDLE : S_QRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Keys, newest hours and bucket valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SERIES; s++) begin
        keys_q[s] <= '0;
        lat_q[s]  <= '0;
      end
      vld_q <= '0;
    end else begin
      for (int s = 0; s < SERIES; s++) begin
        if (cfg_we && s < KEY_REGS && int'(cfg_index_i) == s && keys_q[s] != cfg_data_i) begin
          keys_q[s] <= cfg_data_i;
          lat_q[s]  <= '0;
          for (int i = 0; i < DEPTH; i++) begin
            if (i / WINDOW_HOURS == s) begin
              vld_q[i] <= 1'b0;
            end
          end
        end
      end
      if (state_q == S_DIVM && div_rsp.done && op_q == OP_ADD && hour_q > lasth) begin
        lat_q[ser_q] <= hour_q;
        if (skipped >= WIN_H) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (i / WINDOW_HOURS == int'(ser_q)) begin
              vld_q[i] <= 1'b0;
            end
          end
        end
      end
      if (state_q == S_CLR) begin
        vld_q[base + ADDR_W'(slot_q)] <= 1'b0;
      end
      if (ram_we) begin
        vld_q[fold_addr] <= 1'b1;
      end
    end
  end

  // Item and sequencer datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= opcode_i;
      key_q  <= series_key_i;
      ts_q   <= timestamp_i;
      val_q  <= sample_value_i;
      sval_q <= sample_valid_i;
    end
    if (ram_re) begin
      rd_vld_q <= vld_q[ram_raddr];
    end
    case (state_q)
      S_LOOK: begin
        ser_q    <= match_ser;
        closed_q <= 1'b0;
      end
      S_DIVH: begin
        if (div_rsp.done) begin
          hour_q <= div_rsp.quot[HOUR_W-1:0];
        end
      end
      S_DIVM: begin
        if (div_rsp.done) begin
          rslot_q <= SLOT_W'(div_rsp.rem);
          if (op_q == OP_READ) begin
            // The oldest hour sits one slot after the current one.
            slot_q <= (SLOT_W'(div_rsp.rem) == SLOT_LAST) ? '0
                                                         : SLOT_W'(div_rsp.rem) + 1'b1;
            cnt_q  <= '0;
          end else if (hour_q > lasth) begin
            closed_q <= 1'b1;
            slot_q   <= SLOT_W'(div_rsp.rem);
            cnt_q    <= K_W'(skipped);
          end
        end
      end
      S_CLR: begin
        slot_q <= (slot_q == '0) ? SLOT_LAST : slot_q - 1'b1;
        cnt_q  <= cnt_q - 1'b1;
      end
      S_QDAT: begin
        if (em_load) begin
          slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
          cnt_q  <= cnt_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (em_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_load) begin
      out_status_q <= em_status;
      out_closed_q <= em_closed;
      out_min_q    <= em_min;
      out_max_q    <= em_max;
      out_sum_q    <= em_sum;
      out_cnt_q    <= em_cnt;
      out_last_q   <= em_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign hour_closed_o  = out_closed_q;
  assign bucket_min_o   = out_min_q;
  assign bucket_max_o   = out_max_q;
  assign bucket_sum_o   = out_sum_q;
  assign bucket_count_o = out_cnt_q;
  assign last_o         = out_last_q;

  a_clr_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> cnt_q != '0)
    else $error("clearing pass entered with no slot to clear");

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");

  a_fold_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> vld_q[$past(fold_addr)])
    else $error("folded bucket not marked valid");

  a_emit_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote one not yet taken");

endmodule

FILE: tb/sv/tb_hourly_min_max_sum_ring.sv
module tb_hourly_min_max_sum_ring;
  import hmmsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSER = DEF_SERIES;
  localparam int WIN  = DEF_WINDOW_HOURS;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]              status;
    logic                    closed;
    logic signed [VAL_W-1:0] bmin;
    logic signed [VAL_W-1:0] bmax;
    logic signed [SUM_W-1:0] bsum;
    logic [CNT_W-1:0]        bcnt;
    logic                    last;
  } bucket_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic opcode_i = OP_ADD;
  logic [31:0] series_key_i = '0;
  logic [TS_W-1:0] timestamp_i = '0;
  logic signed [VAL_W-1:0] sample_value_i = '0;
  logic sample_valid_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic hour_closed_o;
  logic signed [VAL_W-1:0] bucket_min_o, bucket_max_o;
  logic signed [SUM_W-1:0] bucket_sum_o;
  logic [CNT_W-1:0] bucket_count_o;
  logic last_o;

  always #6 clk_i = ~clk_i;

  hourly_min_max_sum_ring i_dut (.*);

  // Predictor state.
  logic [31:0]             key_reg [NSER];
  logic [31:0]             newest_hour [NSER];
  logic signed [VAL_W-1:0] ring_min [NSER][WIN];
  logic signed [VAL_W-1:0] ring_max [NSER][WIN];
  logic signed [SUM_W-1:0] ring_sum [NSER][WIN];
  logic [CNT_W-1:0]        ring_cnt [NSER][WIN];

  bucket_rec_t expected_buckets[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  int mismatches = 0, results_seen = 0, items_sent = 0, idle_cycles = 0;
  bit timed_out = 0;

  function automatic void wipe_series(int s);
    newest_hour[s] = 0;
    for (int k = 0; k < WIN; k++) begin
      ring_min[s][k] = 0; ring_max[s][k] = 0; ring_sum[s][k] = 0; ring_cnt[s][k] = 0;
    end
  endfunction

  function automatic int lookup_series(logic [31:0] key);
    if (key == 0) return -1;
    for (int s = 0; s < NSER; s++) if (key_reg[s] == key) return s;
    return -1;
  endfunction

  function automatic bucket_rec_t plain_rec(logic [2:0] st, logic cl);
    bucket_rec_t r;
    r = '0;
    r.status = st; r.closed = cl; r.last = 1'b1;
    return r;
  endfunction

  function automatic void predict_item(logic op, logic [31:0] key, logic [31:0] ts,
                                       logic signed [31:0] val, logic vld);
    int s;
    logic [31:0] hr, now_h, back, h, skipped;
    logic cl;
    int slot;
    longint sum;
    bucket_rec_t r;
    s = lookup_series(key);
    if (op == OP_ADD) begin
      if (!vld || ts < CLOCK_FLOOR) begin
        expected_buckets.push_back(plain_rec(ST_INVALID, 0)); return;
      end
      if (s < 0) begin
        expected_buckets.push_back(plain_rec(ST_UNKNOWN, 0)); return;
      end
      hr = ts / 3600;
      cl = 0;
      if (hr > newest_hour[s]) begin
        skipped = hr - newest_hour[s];
        for (int j = 1; j <= WIN; j++)
          if (skipped >= WIN || j <= skipped) begin
            slot = (newest_hour[s] + j) % WIN;
            ring_min[s][slot] = 0; ring_max[s][slot] = 0;
            ring_sum[s][slot] = 0; ring_cnt[s][slot] = 0;
          end
        newest_hour[s] = hr;
        cl = 1;
      end
      if (!(hr <= newest_hour[s] && newest_hour[s] - hr < WIN)) begin
        expected_buckets.push_back(plain_rec(ST_OUTSIDE, cl)); return;
      end
      slot = hr % WIN;
      if (ring_cnt[s][slot] == 0) begin
        ring_min[s][slot] = val; ring_max[s][slot] = val;
        ring_sum[s][slot] = SUM_W'(longint'(val)); ring_cnt[s][slot] = 1;
      end else begin
        if (val < ring_min[s][slot]) ring_min[s][slot] = val;
        if (val > ring_max[s][slot]) ring_max[s][slot] = val;
        sum = longint'(ring_sum[s][slot]) + longint'(val);
        if (sum > 64'sd140737488355327) sum = 64'sd140737488355327;
        if (sum < -64'sd140737488355328) sum = -64'sd140737488355328;
        ring_sum[s][slot] = SUM_W'(sum);
        if (ring_cnt[s][slot] != CNT_MAX) ring_cnt[s][slot]++;
      end
      r = plain_rec(ST_STORED, cl);
      r.bmin = ring_min[s][slot]; r.bmax = ring_max[s][slot];
      r.bsum = ring_sum[s][slot]; r.bcnt = ring_cnt[s][slot];
      expected_buckets.push_back(r);
      return;
    end
    if (s < 0) begin
      expected_buckets.push_back(plain_rec(ST_UNKNOWN, 0)); return;
    end
    now_h = (ts >= CLOCK_FLOOR) ? ts / 3600 : 0;
    for (int k = 0; k < WIN; k++) begin
      back = WIN - 1 - k;
      h = now_h - back;
      r = '0;
      r.status = ST_RECORD;
      r.last = (k == WIN - 1);
      if (back <= now_h && h <= newest_hour[s] && newest_hour[s] - h < WIN) begin
        slot = h % WIN;
        r.bmin = ring_min[s][slot]; r.bmax = ring_max[s][slot];
        r.bsum = ring_sum[s][slot]; r.bcnt = ring_cnt[s][slot];
      end
      expected_buckets.push_back(r);
    end
  endfunction

  // Receiver: random stalls and the result check.
  always @(posedge clk_i) begin
    bucket_rec_t got, want;
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        got = '{status_o, hour_closed_o, bucket_min_o, bucket_max_o,
                bucket_sum_o, bucket_count_o, last_o};
        if (expected_buckets.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_buckets.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL hourly_min_max_sum_ring");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [31:0] key, logic [31:0] ts,
                           logic signed [31:0] val, logic vld);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i <= op; series_key_i <= key; timestamp_i <= ts;
    sample_value_i <= val; sample_valid_i <= vld;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(op, key, ts, val, vld);
    items_sent++;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (expected_buckets.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_key(int idx, logic [31:0] key);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_IDX_W'(idx);
    cfg_data_i <= key;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < NSER && key_reg[idx] != key) begin
      key_reg[idx] = key;
      wipe_series(idx);
    end
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] base_ts(int hr_off);
    return 32'd1000000000 + 32'(hr_off) * 3600 + 32'($urandom_range(3599));
  endfunction

  task automatic test_directed();
    logic [31:0] t0;
    write_key(0, 32'h1111_0001);
    write_key(1, 32'hFFFF_FFFF);
    write_key(2, 32'h0000_0001);
    write_key(3, 32'h8000_0000);
    write_key(5, 32'hDEAD_BEEF);
    t0 = base_ts(10);
    send_item(OP_ADD, 32'h1111_0001, t0, 32'sh7FFF_FFFF, 1);
    send_item(OP_ADD, 32'h1111_0001, t0, 32'sh8000_0000, 1);
    send_item(OP_ADD, 32'h1111_0001, t0, 32'sh0001_0000, 0);
    send_item(OP_ADD, 32'h1111_0001, 32'd999999999, 32'sh1, 1);
    send_item(OP_ADD, 32'h0, t0, 32'sh1, 1);
    send_item(OP_ADD, 32'h2222_2222, t0, 32'sh1, 1);
    send_item(OP_ADD, 32'h1111_0001, t0 + 5 * 3600, -32'sh10000, 1);
    send_item(OP_ADD, 32'h1111_0001, t0 - 3600, 32'sh5, 1);
    send_item(OP_ADD, 32'h1111_0001, t0 + 200 * 3600, 32'sh5, 1);
    send_item(OP_ADD, 32'h1111_0001, t0, 32'sh5, 1);
    send_item(OP_READ, 32'h1111_0001, t0 + 201 * 3600, 0, 0);
    send_item(OP_READ, 32'h1111_0001, 32'd5, 0, 1);
    send_item(OP_READ, 32'h3333_0000, t0, 0, 0);
    send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 1);
    send_item(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 1);
    send_item(OP_ADD, 32'h8000_0000, 32'd1000000000, 32'sh1234_5678, 1);
    send_item(OP_READ, 32'h8000_0000, 32'd1000000000, 0, 1);
    drain_results();
    // Rewriting the same key leaves the series intact; a new key clears it.
    write_key(0, 32'h1111_0001);
    write_key(2, 32'h0000_0000);
    send_item(OP_READ, 32'h1111_0001, t0 + 201 * 3600, 0, 0);
    send_item(OP_ADD, 32'h0, t0, 32'sh1, 1);
    drain_results();
  endtask

  task automatic test_extreme_values();
    logic [31:0] t;
    write_key(2, 32'h0000_0ACE);
    t = base_ts(40);
    // Full-scale readings of both signs into one bucket, then read it back.
    for (int i = 0; i < 30; i++) begin
      send_item(OP_ADD, 32'h0000_0ACE, t, (i < 15) ? 32'sh7FFF_FFFF : 32'sh8000_0000, 1);
    end
    send_item(OP_READ, 32'h0000_0ACE, t, 0, 0);
    drain_results();
  endtask

  task automatic test_random(int n);
    logic [31:0] keys [4];
    logic [31:0] clock_s, key, ts;
    int pick;
    keys[0] = 32'h1111_0001; keys[1] = 32'hFFFF_FFFF;
    keys[2] = 32'h0000_0ACE; keys[3] = 32'h8000_0000;
    clock_s = 32'd1000000000 + $urandom_range(1000000);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      clock_s += $urandom_range(99) < 70 ? $urandom_range(2000) : $urandom_range(120000);
      key = (pick < 85) ? keys[$urandom_range(3)] : $urandom;
      ts = clock_s - ($urandom_range(99) < 20 ? $urandom_range(100000) : 0);
      if ($urandom_range(99) < 5) ts = $urandom;
      if (pick % 5 == 0)
        send_item(OP_READ, key, ts, $urandom, $urandom_range(1));
      else
        send_item(OP_ADD, key, ts, $urandom, $urandom_range(99) < 90);
    end
  endtask

  initial begin
    for (int s = 0; s < NSER; s++) begin
      key_reg[s] = 0;
      wipe_series(s);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extreme_values();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(60);
    send_idle_pct = 64; recv_stall_pct = 0;  test_random(60);
    // Hold off until the block has emptied, then continue.
    drain_results();
    send_idle_pct = 0;  recv_stall_pct = 64; test_random(60);
    send_idle_pct = 17; recv_stall_pct = 17; test_random(60);
    drain_results();
    send_idle_pct = 0;  recv_stall_pct = 0;
    write_key(1, 32'h0BAD_F00D);
    write_key(3, 32'h0000_0000);
    test_random(20);
    drain_results();
    $display("Covered %0d items and %0d results over key changes and idle mixes.",
             items_sent, results_seen);
    if (mismatches == 0 && expected_buckets.size() == 0)
      $display("PASS hourly_min_max_sum_ring");
    else
      $display("FAIL hourly_min_max_sum_ring");
    $finish;
  end

endmodule
